### hw/rtl/ptts_pkg.sv
package ptts_pkg;

   // Image store and candidate search sizing
   localparam int MAX_PIXELS      = 65536;
   localparam int STEP_SIZE       = 8;
   localparam int CANDIDATE_STEPS = 4;
   localparam int NUM_SLOTS       = 2 * CANDIDATE_STEPS + 1;

   localparam int ADDR_W  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CNT_W   = $clog2(MAX_PIXELS + 1);
   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int STEP_W  = $clog2(CANDIDATE_STEPS + 1);

   // Pixel, cutoff and percent arithmetic widths
   localparam int PIX_W     = 8;
   localparam int CUT_W     = 9;
   localparam int PCT_W     = 7;
   localparam int PCT_SCALE = 100;
   localparam int PROD_W    = CNT_W + PCT_W;

   // Front-to-back queue
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_TARGET   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_BASE     = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_INVERT   = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_ADAPTIVE = 2'd3;

   // Request opcodes
   localparam logic OP_LOAD    = 1'b0;
   localparam logic OP_READOUT = 1'b1;

   typedef enum logic [1:0] {
      KIND_PIXEL      = 2'd0,
      KIND_PIXEL_LAST = 2'd1,
      KIND_READOUT    = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type         kind;
      logic [PIX_W-1:0] pixel;
   } entry_type;

   typedef struct packed {
      logic [PCT_W-1:0] target;
      logic [PIX_W-1:0] base;
      logic             invert;
      logic             adaptive;
   } cfg_type;

   // Cutoff of one candidate slot, saturated to -1..255.
   // Slot 0 is the base, 1..N go down by steps, N+1..2N go up.
   function automatic logic signed [CUT_W-1:0] slot_cut(input logic [SLOT_W-1:0] slot,
                                                       input logic [PIX_W-1:0] base);
      int v;
      if (slot == '0) begin
         v = int'(base);
      end else if (int'(slot) <= CANDIDATE_STEPS) begin
         v = int'(base) - STEP_SIZE * int'(slot);
      end else begin
         v = int'(base) + STEP_SIZE * (int'(slot) - CANDIDATE_STEPS);
      end
      if (v < -1) begin
         v = -1;
      end else if (v > 255) begin
         v = 255;
      end
      return CUT_W'(v);
   endfunction

   // Distance between two scaled percent values
   function automatic logic [PROD_W-1:0] abs_diff(input logic [PROD_W-1:0] a,
                                                 input logic [PROD_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

### hw/rtl/percent_target_threshold_search.sv
// Load request: one per cycle unless the search or a stalled readout backs up the queue;
// it passes the front slot and the queue before the store. Final load in adaptive mode:
// the search runs INIT and DIR, then MUL and CMP per candidate step. Readout request:
// it goes via the front slot, queue, registered memory read and output register; another
// is taken only once READ has returned to IDLE. Synchronous active-high reset clears the
// config registers, counts, queue and flags; the frame memory is not cleared.
module percent_target_threshold_search
   import ptts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [PIX_W-1:0]        req_pixel_in,
   input  logic                    req_load_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PIX_W-1:0]        rsp_pixel_out,
   output logic                    rsp_out_last,
   output logic signed [CUT_W-1:0] rsp_cutoff_used,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output logic [CSR_DATA_W-1:0]   prdata,
   output logic                    pready
);

   cfg_type               cfg_ff, cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  push_valid, push_ready;
   entry_type             push_entry;
   logic                  q_valid, q_pop;
   entry_type             q_entry;

   // register file
   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (psel && penable && pwrite) begin
         unique case (reg_idx)
            REG_TARGET:   cfg_in.target   = pwdata[PCT_W-1:0];
            REG_BASE:     cfg_in.base     = pwdata[PIX_W-1:0];
            REG_INVERT:   cfg_in.invert   = pwdata[0];
            REG_ADAPTIVE: cfg_in.adaptive = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_TARGET:   prdata = CSR_DATA_W'(cfg_ff.target);
         REG_BASE:     prdata = CSR_DATA_W'(cfg_ff.base);
         REG_INVERT:   prdata = CSR_DATA_W'(cfg_ff.invert);
         REG_ADAPTIVE: prdata = CSR_DATA_W'(cfg_ff.adaptive);
         default:      prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.target   <= PCT_W'(5);
         cfg_ff.base     <= PIX_W'(64);
         cfg_ff.invert   <= 1'b0;
         cfg_ff.adaptive <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ptts_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_pixel_in  (req_pixel_in),
      .req_load_last (req_load_last),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_entry    (push_entry)
   );

   ptts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_entry  (q_entry)
   );

   ptts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_entry         (q_entry),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_last    (rsp_out_last),
      .rsp_cutoff_used (rsp_cutoff_used)
   );

endmodule

### hw/rtl/ptts_front.sv
module ptts_front
   import ptts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_opcode,
   input  logic [PIX_W-1:0] req_pixel_in,
   input  logic             req_load_last,
   output logic             push_valid,
   input  logic             push_ready,
   output entry_type        push_entry
);

   logic      slot_valid_ff, slot_valid_in;
   entry_type slot_ff, slot_in;
   logic      req_fire;

   // request stage: free, or drains into the queue this cycle
   assign req_ready  = !slot_valid_ff || push_ready;
   assign req_fire   = req_valid && req_ready;
   assign push_valid = slot_valid_ff;
   assign push_entry = slot_ff;

   // classify the request
   always_comb begin
      slot_in = slot_ff;
      if (req_fire) begin
         slot_in.pixel = req_pixel_in;
         priority if (req_opcode == OP_READOUT) begin
            slot_in.kind = KIND_READOUT;
         end else if (req_load_last) begin
            slot_in.kind = KIND_PIXEL_LAST;
         end else begin
            slot_in.kind = KIND_PIXEL;
         end
      end
   end

   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (req_fire) begin
         slot_valid_in = 1'b1;
      end else if (push_ready) begin
         slot_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

### hw/rtl/ptts_queue.sv
module ptts_queue
   import ptts_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   output logic      push_ready,
   input  entry_type push_entry,
   output logic      pop_valid,
   input  logic      pop,
   output entry_type pop_entry
);

   entry_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hw/rtl/ptts_back.sv
module ptts_back
   import ptts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  entry_type               q_entry,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [PIX_W-1:0]        rsp_pixel_out,
   output logic                    rsp_out_last,
   output logic signed [CUT_W-1:0] rsp_cutoff_used
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_INIT = 6'b000010,
      ST_DIR  = 6'b000100,
      ST_MUL  = 6'b001000,
      ST_CMP  = 6'b010000,
      ST_READ = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff [NUM_SLOTS];
   logic [CNT_W-1:0]        cnt_in [NUM_SLOTS];
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [CNT_W-1:0]        rd_idx_ff, rd_idx_in;
   logic                    ready_ff, ready_in;
   logic signed [CUT_W-1:0] chosen_ff, chosen_in;

   // threshold search registers
   logic [PROD_W-1:0]       goal_ff, goal_in;
   logic [PROD_W-1:0]       scaled_ff, scaled_in;
   logic [PROD_W-1:0]       best_dist_ff, best_dist_in;
   logic signed [CUT_W-1:0] best_cut_ff, best_cut_in;
   logic                    down_ff, down_in;
   logic [STEP_W-1:0]       k_ff, k_in;
   logic [SLOT_W-1:0]       cand_slot;
   logic [PROD_W-1:0]       gap;
   logic signed [CUT_W-1:0] cut_sel;

   // frame memory
   logic [PIX_W-1:0]        frame_mem [MAX_PIXELS];
   logic [PIX_W-1:0]        rd_data_ff;
   logic                    rd_last_ff, rd_last_in;
   logic                    mem_we, mem_re;
   logic [ADDR_W-1:0]       wr_addr;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PIX_W-1:0]        rsp_pixel_ff, rsp_pixel_in;
   logic                    rsp_last_ff, rsp_last_in;
   logic signed [CUT_W-1:0] rsp_cut_ff, rsp_cut_in;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_out   = rsp_pixel_ff;
   assign rsp_out_last    = rsp_last_ff;
   assign rsp_cutoff_used = rsp_cut_ff;

   // candidate slot under test: lower or upper side
   assign cand_slot = down_ff ? (SLOT_W'(1) + SLOT_W'(k_ff))
                              : (SLOT_W'(CANDIDATE_STEPS + 1) + SLOT_W'(k_ff));
   assign gap       = abs_diff(goal_ff, scaled_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      total_in     = total_ff;
      rd_idx_in    = rd_idx_ff;
      ready_in     = ready_ff;
      chosen_in    = chosen_ff;
      goal_in      = goal_ff;
      scaled_in    = scaled_ff;
      best_dist_in = best_dist_ff;
      best_cut_in  = best_cut_ff;
      down_in      = down_ff;
      k_in         = k_ff;
      rd_last_in   = rd_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      wr_addr      = '0;
      q_pop        = 1'b0;
      cut_sel      = best_cut_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_cut_in   = rsp_cut_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_entry.kind == KIND_PIXEL || q_entry.kind == KIND_PIXEL_LAST) begin
                  // a load after a finished image starts a new one
                  if (ready_ff) begin
                     for (int s = 0; s < NUM_SLOTS; s++) begin
                        cnt_in[s] = '0;
                     end
                     total_in  = '0;
                     rd_idx_in = '0;
                     ready_in  = 1'b0;
                  end
                  // store and count unless the store is full
                  if (total_in < CNT_W'(MAX_PIXELS)) begin
                     mem_we  = 1'b1;
                     wr_addr = total_in[ADDR_W-1:0];
                     for (int s = 0; s < NUM_SLOTS; s++) begin
                        if ($signed({1'b0, q_entry.pixel}) > slot_cut(SLOT_W'(s), cfg.base)) begin
                           cnt_in[s] = cnt_in[s] + CNT_W'(1);
                        end
                     end
                     total_in = total_in + CNT_W'(1);
                  end
                  if (q_entry.kind == KIND_PIXEL_LAST) begin
                     if (cfg.adaptive && total_in != '0) begin
                        state_in = ST_INIT;
                     end else begin
                        chosen_in = slot_cut('0, cfg.base);
                        ready_in  = 1'b1;
                        rd_idx_in = '0;
                     end
                  end
               end else if (q_entry.kind == KIND_READOUT) begin
                  // readout only while pixels remain
                  if (ready_ff && rd_idx_ff < total_ff) begin
                     mem_re     = 1'b1;
                     rd_last_in = (rd_idx_ff + CNT_W'(1) == total_ff);
                     rd_idx_in  = rd_idx_ff + CNT_W'(1);
                     state_in   = ST_READ;
                  end
               end
            end
         end
         ST_INIT: begin
            goal_in     = PROD_W'(cfg.target) * PROD_W'(total_ff);
            scaled_in   = PROD_W'(cnt_ff[0]) * PROD_W'(PCT_SCALE);
            best_cut_in = slot_cut('0, cfg.base);
            state_in    = ST_DIR;
         end
         ST_DIR: begin
            // baseline under target: search lower cutoffs
            down_in      = (scaled_ff < goal_ff);
            best_dist_in = gap;
            k_in         = '0;
            state_in     = ST_MUL;
         end
         ST_MUL: begin
            scaled_in = PROD_W'(cnt_ff[cand_slot]) * PROD_W'(PCT_SCALE);
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            if (gap < best_dist_ff) begin
               best_dist_in = gap;
               cut_sel      = slot_cut(cand_slot, cfg.base);
            end
            best_cut_in = cut_sel;
            if (k_ff == STEP_W'(CANDIDATE_STEPS - 1)) begin
               chosen_in = cut_sel;
               ready_in  = 1'b1;
               rd_idx_in = '0;
               state_in  = ST_IDLE;
            end else begin
               k_in     = k_ff + STEP_W'(1);
               state_in = ST_MUL;
            end
         end
         ST_READ: begin
            // binarize once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = (($signed({1'b0, rd_data_ff}) > chosen_ff) ? {PIX_W{1'b1}} : '0)
                              ^ {PIX_W{cfg.invert}};
               rsp_last_in  = rd_last_ff;
               rsp_cut_in   = chosen_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '{default: '0};
         total_ff     <= '0;
         rd_idx_ff    <= '0;
         ready_ff     <= 1'b0;
         chosen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         rd_idx_ff    <= rd_idx_in;
         ready_ff     <= ready_in;
         chosen_ff    <= chosen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      goal_ff      <= goal_in;
      scaled_ff    <= scaled_in;
      best_dist_ff <= best_dist_in;
      best_cut_ff  <= best_cut_in;
      down_ff      <= down_in;
      k_ff         <= k_in;
      rd_last_ff   <= rd_last_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_cut_ff   <= rsp_cut_in;
   end

   // frame memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem[wr_addr] <= q_entry.pixel;
      end
      if (mem_re) begin
         rd_data_ff <= frame_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   // checks
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(MAX_PIXELS))
      else $error("pixel total beyond store size");

   a_read_bound: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> rd_idx_ff <= total_ff)
      else $error("read index passed pixel total");

   a_binary_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_pixel_ff == '0 || rsp_pixel_ff == {PIX_W{1'b1}}))
      else $error("output pixel not binary");

   a_search_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP && k_ff == STEP_W'(CANDIDATE_STEPS - 1)) |=>
         (ready_ff && state_ff == ST_IDLE))
      else $error("search end did not mark image ready");

   a_cut_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_cut_ff >= -CUT_W'(1))
      else $error("cutoff below saturation floor");

endmodule

### bench/threshold_readout_checker.sv
`timescale 1ns / 1ps

module threshold_readout_checker
   import ptts_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [PIX_W-1:0]        req_pixel_in,
   input  logic                    req_load_last,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [PIX_W-1:0]        rsp_pixel_out,
   input  logic                    rsp_out_last,
   input  logic signed [CUT_W-1:0] rsp_cutoff_used,
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic                    pready,
   input  logic [CSR_ADDR_W-1:0]   paddr,
   input  logic [CSR_DATA_W-1:0]   pwdata,
   output int                      mismatches,
   output int                      results_owed,
   output int                      results_checked
);

   localparam logic [PCT_W-1:0] TARGET_AT_RESET = 7'd5;
   localparam logic [PIX_W-1:0] BASE_AT_RESET   = 8'd64;

   typedef struct packed {
      logic [PIX_W-1:0]        pixel;
      logic                    last;
      logic signed [CUT_W-1:0] cutoff;
   } binarized_type;

   cfg_type          cfg;
   logic [PIX_W-1:0] frame_copy [MAX_PIXELS];
   int               above_counts [NUM_SLOTS];
   int               pixels_held;
   int               next_read;
   int               picked_cutoff;
   logic             image_done;
   binarized_type    owed_pixels [$];

   // Saturated cutoff of a candidate: 0 is the base, 1..N step down, N+1..2N step up
   function automatic int candidate_cutoff(input int slot, input int base);
      int c;
      if (slot == 0) c = base;
      else if (slot <= CANDIDATE_STEPS) c = base - STEP_SIZE * slot;
      else c = base + STEP_SIZE * (slot - CANDIDATE_STEPS);
      if (c < -1) c = -1;
      else if (c > 255) c = 255;
      return c;
   endfunction

   // Threshold for the finished image; percent compares done as count*100 vs target*total
   function automatic int search_cutoff();
      longint goal;
      longint best_scaled;
      longint scaled;
      longint gap_new;
      longint gap_best;
      int     first;
      int     best_cut;
      best_cut = int'(cfg.base);
      if (!cfg.adaptive || pixels_held == 0) return best_cut;
      goal        = longint'(cfg.target) * longint'(pixels_held);
      best_scaled = longint'(above_counts[0]) * PCT_SCALE;
      // under target: try lower cutoffs, otherwise higher ones
      first = (best_scaled < goal) ? 1 : CANDIDATE_STEPS + 1;
      for (int k = 0; k < CANDIDATE_STEPS; k++) begin
         scaled   = longint'(above_counts[first + k]) * PCT_SCALE;
         gap_new  = (goal > scaled) ? goal - scaled : scaled - goal;
         gap_best = (goal > best_scaled) ? goal - best_scaled : best_scaled - goal;
         if (gap_new < gap_best) begin
            best_scaled = scaled;
            best_cut    = candidate_cutoff(first + k, int'(cfg.base));
         end
      end
      return best_cut;
   endfunction

   always @(posedge clock) begin
      binarized_type    want;
      logic [PIX_W-1:0] bin;
      if (reset) begin
         cfg.target    = TARGET_AT_RESET;
         cfg.base      = BASE_AT_RESET;
         cfg.invert    = 1'b0;
         cfg.adaptive  = 1'b0;
         foreach (above_counts[s]) above_counts[s] = 0;
         pixels_held   = 0;
         next_read     = 0;
         picked_cutoff = 0;
         image_done    = 1'b0;
         owed_pixels.delete();
         mismatches      = 0;
         results_checked = 0;
      end else begin
         // register writes (only issued while the block is idle)
         if (psel && penable && pwrite && pready) begin
            case (paddr[CSR_ADDR_W-1:2])
               REG_TARGET:   cfg.target   = pwdata[PCT_W-1:0];
               REG_BASE:     cfg.base     = pwdata[PIX_W-1:0];
               REG_INVERT:   cfg.invert   = pwdata[0];
               REG_ADAPTIVE: cfg.adaptive = pwdata[0];
               default: ;
            endcase
         end

         // compare each result pixel against the oldest prediction
         if (rsp_valid && rsp_ready) begin
            if (owed_pixels.size() == 0) begin
               $error("unexpected result: pixel_out %0d out_last %0d cutoff_used %0d",
                      rsp_pixel_out, rsp_out_last, rsp_cutoff_used);
               mismatches++;
            end else begin
               want = owed_pixels.pop_front();
               results_checked++;
               if (rsp_pixel_out !== want.pixel) begin
                  $error("pixel_out mismatch: expected %0d, actual %0d",
                         want.pixel, rsp_pixel_out);
                  mismatches++;
               end
               if (rsp_out_last !== want.last) begin
                  $error("out_last mismatch: expected %0d, actual %0d",
                         want.last, rsp_out_last);
                  mismatches++;
               end
               if (rsp_cutoff_used !== want.cutoff) begin
                  $error("cutoff_used mismatch: expected %0d, actual %0d",
                         want.cutoff, rsp_cutoff_used);
                  mismatches++;
               end
            end
         end

         // track accepted requests
         if (req_valid && req_ready) begin
            if (req_opcode == OP_LOAD) begin
               // first pixel after a finished image starts a new one
               if (image_done) begin
                  foreach (above_counts[s]) above_counts[s] = 0;
                  pixels_held = 0;
                  next_read   = 0;
                  image_done  = 1'b0;
               end
               // a full store drops the pixel but still honors load_last
               if (pixels_held < MAX_PIXELS) begin
                  frame_copy[pixels_held] = req_pixel_in;
                  foreach (above_counts[s])
                     if (int'(req_pixel_in) > candidate_cutoff(s, int'(cfg.base)))
                        above_counts[s]++;
                  pixels_held++;
               end
               if (req_load_last) begin
                  picked_cutoff = search_cutoff();
                  next_read     = 0;
                  image_done    = 1'b1;
               end
            end else if (image_done && next_read < pixels_held) begin
               bin = (int'(frame_copy[next_read]) > picked_cutoff) ? 8'hFF : 8'h00;
               if (cfg.invert) bin = ~bin;
               want.pixel  = bin;
               want.last   = (next_read + 1 == pixels_held);
               want.cutoff = CUT_W'(picked_cutoff);
               owed_pixels.push_back(want);
               next_read++;
            end
         end
      end
      results_owed = owed_pixels.size();
   end

endmodule

### bench/percent_target_threshold_search_tb.sv
`timescale 1ns / 1ps

module percent_target_threshold_search_tb;
   import ptts_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int SETTLE_CYCLES = 40;

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic                    req_opcode;
   logic [PIX_W-1:0]        req_pixel_in;
   logic                    req_load_last;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [PIX_W-1:0]        rsp_pixel_out;
   logic                    rsp_out_last;
   logic signed [CUT_W-1:0] rsp_cutoff_used;
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CSR_ADDR_W-1:0]   paddr;
   logic [CSR_DATA_W-1:0]   pwdata;
   logic [CSR_DATA_W-1:0]   prdata;
   logic                    pready;

   int mismatches;
   int results_owed;
   int results_checked;

   int send_idle_pct;
   int recv_idle_pct;
   int items_sent;
   int loads_sent;
   int images_sent;
   int config_writes;
   int cur_base;
   int hold_seq  = 0;
   int hold_seen = 0;
   int hold_left = 0;

   percent_target_threshold_search u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pixel_in    (req_pixel_in),
      .req_load_last   (req_load_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_last    (rsp_out_last),
      .rsp_cutoff_used (rsp_cutoff_used),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   threshold_readout_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_pixel_in    (req_pixel_in),
      .req_load_last   (req_load_last),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_out_last    (rsp_out_last),
      .rsp_cutoff_used (rsp_cutoff_used),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .pready          (pready),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .mismatches      (mismatches),
      .results_owed    (results_owed),
      .results_checked (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // overall time limit
   initial begin
      #2_000_000;
      $display("FAIL percent_target_threshold_search");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_seq) begin
         rsp_ready <= 1'b0;
         hold_seen <= hold_seq;
         hold_left <= HOLD_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one request; returns at the edge where it was accepted, valid left high
   task automatic send_req(input logic op, input logic [PIX_W-1:0] pix, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_pixel_in  <= pix;
      req_load_last <= last;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      items_sent++;
      if (op == OP_LOAD) loads_sent++;
   endtask

   // drain: no result owed, then let in-flight loads and the search finish
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // returns at the write edge with the bus still in its access phase
   task automatic write_reg(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      @(posedge clock);
      config_writes++;
   endtask

   // all four registers; junk above each field should be dropped
   task automatic set_config(input int target, input int base, input bit inv, input bit adapt);
      wait_idle();
      write_reg(REG_TARGET,   32'(target) | ($urandom << PCT_W));
      write_reg(REG_BASE,     32'(base)   | ($urandom << PIX_W));
      write_reg(REG_INVERT,   32'(inv)    | ($urandom << 1));
      write_reg(REG_ADAPTIVE, 32'(adapt)  | ($urandom << 1));
      // release the bus after the last write
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      cur_base = base;
   endtask

   task automatic random_config();
      int target;
      int base;
      target = ($urandom_range(99) < 20) ? 100 * $urandom_range(1) : $urandom_range(100);
      base   = ($urandom_range(99) < 20) ? 255 * $urandom_range(1) : $urandom_range(255);
      set_config(target, base, $urandom_range(1), $urandom_range(99) < 75);
   endtask

   // half uniform, half near the base cutoff so the candidates differ
   function automatic logic [PIX_W-1:0] pick_pixel();
      int v;
      if ($urandom_range(1) == 0) return PIX_W'($urandom);
      v = cur_base - 40 + int'($urandom_range(80));
      if (v < 0) v = 0;
      else if (v > 255) v = 255;
      return PIX_W'(v);
   endfunction

   // an image of n pixels, with stray readouts mixed in at stray_pct
   task automatic load_image(input int n, input int stray_pct);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < stray_pct)
            send_req(OP_READOUT, PIX_W'($urandom), $urandom_range(1));
         send_req(OP_LOAD, pick_pixel(), i == n - 1);
      end
      images_sent++;
   endtask

   task automatic read_out(input int n);
      for (int i = 0; i < n; i++)
         send_req(OP_READOUT, PIX_W'($urandom), $urandom_range(1));
   endtask

   task automatic run_images(input int budget);
      int stop_at;
      int n;
      stop_at = items_sent + budget;
      while (items_sent < stop_at) begin
         if ($urandom_range(99) < 15) random_config();
         n = ($urandom_range(99) < 6) ? $urandom_range(64, 40) : $urandom_range(20, 1);
         load_image(n, ($urandom_range(99) < 15) ? 10 : 0);
         // mostly full readouts, some running past the end, some abandoned
         if ($urandom_range(99) < 85) read_out(n + $urandom_range(2));
         else read_out($urandom_range(n - 1));
      end
   endtask

   // receiver holds off while readouts keep coming, so the block backs up
   task automatic flood_while_held();
      load_image(24, 0);
      hold_seq <= hold_seq + 1;
      read_out(24);
   endtask

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_opcode    <= OP_LOAD;
      req_pixel_in  <= '0;
      req_load_last <= 1'b0;
      psel          <= 1'b0;
      penable       <= 1'b0;
      pwrite        <= 1'b0;
      paddr         <= '0;
      pwdata        <= '0;
      send_idle_pct = 15;
      recv_idle_pct = 55;
      items_sent    = 0;
      loads_sent    = 0;
      images_sent   = 0;
      config_writes = 0;
      cur_base      = 64;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // readout with no image yet gives nothing
      send_req(OP_READOUT, 8'hFF, 1'b1);
      // settings out of reset: fixed cutoff 64, pixels at and just over it
      send_req(OP_LOAD, 8'd0, 1'b0);
      send_req(OP_LOAD, 8'd255, 1'b0);
      send_req(OP_LOAD, 8'd64, 1'b0);
      send_req(OP_LOAD, 8'd65, 1'b1);
      images_sent++;
      read_out(5);
      // search downward into the -1 floor, inverted output,
      // readout during a load gives nothing
      set_config(100, 0, 1'b1, 1'b1);
      send_req(OP_LOAD, 8'd0, 1'b0);
      send_req(OP_READOUT, 8'd0, 1'b0);
      send_req(OP_LOAD, 8'd3, 1'b0);
      send_req(OP_LOAD, 8'd200, 1'b1);
      images_sent++;
      read_out(3);
      // search upward into the 255 ceiling, single-pixel image
      set_config(0, 255, 1'b0, 1'b1);
      send_req(OP_LOAD, 8'd250, 1'b1);
      images_sent++;
      read_out(2);
      // base cutoff moved partway through a load
      set_config(50, 100, 1'b0, 1'b1);
      send_req(OP_LOAD, 8'd90, 1'b0);
      send_req(OP_LOAD, 8'd110, 1'b0);
      send_req(OP_LOAD, 8'd130, 1'b0);
      set_config(50, 120, 1'b0, 1'b1);
      send_req(OP_LOAD, 8'd125, 1'b0);
      send_req(OP_LOAD, 8'd140, 1'b1);
      images_sent++;
      read_out(5);

      // random images: slow receiver, then slow sender, then no idling
      run_images(340);
      flood_while_held();
      send_idle_pct = 55;
      recv_idle_pct = 15;
      run_images(340);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_images(340);
      flood_while_held();

      // a last small image under fresh settings, read past its end
      set_config(30, 128, 1'b0, 1'b1);
      load_image(5, 0);
      read_out(6);

      wait_idle();
      $display("Covered %0d requests (%0d pixel loads) in %0d images, with stray readouts.",
               items_sent, loads_sent, images_sent);
      $display("%0d register writes over several settings; %0d result pixels checked.",
               config_writes, results_checked);
      if (mismatches == 0) begin
         $display("PASS percent_target_threshold_search");
      end else begin
         $display("FAIL percent_target_threshold_search");
      end
      $finish;
   end

endmodule
